>>> design/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the EDF task scheduler: command and status
// codes, slot cell operations, scan flags and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

	localparam int DEF_TASK_SLOTS    = 8;
	localparam int DEF_DEADLINE_BITS = 16;
	localparam int DEF_SLOT_W        = $clog2(DEF_TASK_SLOTS);

	localparam int CMD_W       = 3;
	localparam int SLOT_PORT_W = 3;
	localparam int DL_PORT_W   = 16;
	localparam int STATUS_W    = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACT_TASK  = 3'd0,
		CMD_ACT_IRQ   = 3'd1,
		CMD_TERMINATE = 3'd2,
		CMD_DISPATCH  = 3'd3,
		CMD_RESCHED   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_DUP      = 3'd1,
		STAT_NORUN    = 3'd2,
		STAT_NOREADY  = 3'd3,
		STAT_DISABLED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACTIVATE,
		OP_TERMINATE,
		OP_SET_READY,
		OP_CLR_READY
	} cell_op_t;

	typedef struct packed {
		logic valid;
		logic found;
		logic hit;
	} scan_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LAUNCH,
		ST_WAIT,
		ST_RESULT
	} sched_state_t;

endpackage

`default_nettype wire

>>> design/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One task slot: active/ready bits and deadline, plus one stage of the scan
// chain that carries the running minimum and the preemption hit.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_cell #(
	parameter int SLOT_W   = edf_pkg::DEF_SLOT_W,
	parameter int DL_W     = edf_pkg::DEF_DEADLINE_BITS,
	parameter int CELL_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  edf_pkg::cell_op_t    ctrl_op,
	input  logic [SLOT_W-1:0]    ctrl_idx,
	input  logic [DL_W-1:0]      ctrl_dl,
	input  logic [DL_W-1:0]      cur_dl,
	input  edf_pkg::scan_flags_t scan_in,
	input  logic [SLOT_W-1:0]    scan_in_idx,
	input  logic [DL_W-1:0]      scan_in_dl,
	output edf_pkg::scan_flags_t scan_out,
	output logic [SLOT_W-1:0]    scan_out_idx,
	output logic [DL_W-1:0]      scan_out_dl,
	output logic                 active
);
	import edf_pkg::*;

	logic              active_q;
	logic              ready_q;
	logic [DL_W-1:0]   dl_q;
	scan_flags_t       flags_q;
	logic [SLOT_W-1:0] idx_q;
	logic [DL_W-1:0]   best_dl_q;
	logic              sel;
	logic              eligible;
	logic              take;
	logic              beats_cur;

	assign sel       = (ctrl_idx == SLOT_W'(CELL_IDX));
	assign eligible  = active_q & ready_q;
	// strict compare keeps the lowest index on ties
	assign take      = eligible & (!scan_in.found || (dl_q < scan_in_dl));
	assign beats_cur = eligible & (dl_q < cur_dl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ready_q  <= 1'b0;
		end else if (sel) begin
			case (ctrl_op)
				OP_ACTIVATE: begin
					active_q <= 1'b1;
					ready_q  <= 1'b1;
				end
				OP_TERMINATE: begin
					active_q <= 1'b0;
					ready_q  <= 1'b0;
				end
				OP_SET_READY: ready_q <= 1'b1;
				OP_CLR_READY: ready_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctrl_op == OP_ACTIVATE) begin
			dl_q <= ctrl_dl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.valid <= scan_in.valid;
			flags_q.found <= scan_in.found | eligible;
			flags_q.hit   <= scan_in.hit | beats_cur;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= take ? SLOT_W'(CELL_IDX) : scan_in_idx;
		best_dl_q <= take ? dl_q : scan_in_dl;
	end

	assign scan_out     = flags_q;
	assign scan_out_idx = idx_q;
	assign scan_out_dl  = best_dl_q;
	assign active       = active_q;

endmodule

`default_nettype wire

>>> design/edf_task_scheduler.sv
// Flow: commands without a scan pass ST_EXEC and ST_RESULT to the output
//   register; dispatch and preemption checks also pass ST_LAUNCH and ST_WAIT.
// Throughput: one command at a time; the scan token walks the slot chain one
//   cell per cycle, so the chain length sets the scan commands' cost.
// Reset: all slots inactive, nothing running, scheduler disabled, output empty.
// ----------------------------------------------------------------------------
// edf_task_scheduler
// Earliest-deadline-first scheduler: command controller in front of a chain
// of slot cells that is scanned for the most urgent ready task.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_task_scheduler #(
	parameter int TASK_SLOTS    = edf_pkg::DEF_TASK_SLOTS,
	parameter int DEADLINE_BITS = edf_pkg::DEF_DEADLINE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [edf_pkg::CMD_W-1:0]        cmd,
	input  logic [edf_pkg::SLOT_PORT_W-1:0]  task_slot,
	input  logic [edf_pkg::DL_PORT_W-1:0]    task_deadline,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [edf_pkg::STATUS_W-1:0]     status,
	output logic                             running_valid,
	output logic [edf_pkg::SLOT_PORT_W-1:0]  running_slot,
	output logic                             preempted
);
	import edf_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int DL_W   = DEADLINE_BITS;

	sched_state_t      state_q, state_d;
	logic              enable_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_PORT_W-1:0] slot_q;
	logic [DL_W-1:0]   dl_q;
	logic              dispatch_q, dispatch_d;
	logic              cur_valid_q, cur_valid_d;
	logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
	logic [DL_W-1:0]   cur_dl_q, cur_dl_d;
	status_t           status_q, status_d;
	logic              pre_q, pre_d;

	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_run_valid_q;
	logic [SLOT_PORT_W-1:0] out_run_slot_q;
	logic              out_pre_q;
	logic              out_load;

	logic              in_accept;
	logic [DL_W+DL_PORT_W-1:0]    dl_wide;
	logic [SLOT_W+SLOT_PORT_W-1:0] slot_wide;
	logic [SLOT_W+SLOT_PORT_W-1:0] cur_wide;
	logic [SLOT_W-1:0] act_idx;
	logic              slot_in_range;

	cell_op_t          cell_op;
	logic [SLOT_W-1:0] cell_idx;
	logic              launch;
	logic [TASK_SLOTS-1:0] active_vec;

	scan_flags_t       chain_flags [TASK_SLOTS+1];
	logic [SLOT_W-1:0] chain_idx   [TASK_SLOTS+1];
	logic [DL_W-1:0]   chain_dl    [TASK_SLOTS+1];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid & ~in_stall;

	assign dl_wide       = {DL_W'(0), task_deadline};
	assign slot_wide     = {SLOT_W'(0), slot_q};
	assign cur_wide      = {SLOT_PORT_W'(0), cur_slot_q};
	assign act_idx       = slot_wide[SLOT_W-1:0];
	assign slot_in_range = (int'(slot_q) < TASK_SLOTS);

	// scan seed enters cell 0
	assign chain_flags[0] = '{valid: launch, found: 1'b0, hit: 1'b0};
	assign chain_idx[0]   = '0;
	assign chain_dl[0]    = '0;

	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		edf_cell #(
			.SLOT_W   (SLOT_W),
			.DL_W     (DL_W),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl_op      (cell_op),
			.ctrl_idx     (cell_idx),
			.ctrl_dl      (dl_q),
			.cur_dl       (cur_dl_q),
			.scan_in      (chain_flags[i]),
			.scan_in_idx  (chain_idx[i]),
			.scan_in_dl   (chain_dl[i]),
			.scan_out     (chain_flags[i+1]),
			.scan_out_idx (chain_idx[i+1]),
			.scan_out_dl  (chain_dl[i+1]),
			.active       (active_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= cmd;
			slot_q <= task_slot;
			dl_q   <= dl_wide[DL_W-1:0];
		end
	end

	always_comb begin
		state_d     = state_q;
		dispatch_d  = dispatch_q;
		cur_valid_d = cur_valid_q;
		cur_slot_d  = cur_slot_q;
		cur_dl_d    = cur_dl_q;
		status_d    = status_q;
		pre_d       = pre_q;
		cell_op     = OP_NOP;
		cell_idx    = act_idx;
		launch      = 1'b0;
		out_load    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				status_d = STAT_OK;
				pre_d    = 1'b0;
				state_d  = ST_RESULT;
				if (!enable_q) begin
					status_d = STAT_DISABLED;
				end else begin
					case (cmd_q)
						CMD_ACT_TASK, CMD_ACT_IRQ: begin
							if (!slot_in_range || active_vec[act_idx]) begin
								status_d = STAT_DUP;
							end else begin
								cell_op = OP_ACTIVATE;
								if (cmd_q == CMD_ACT_TASK && cur_valid_q) begin
									dispatch_d = 1'b0;
									state_d    = ST_LAUNCH;
								end
							end
						end
						CMD_TERMINATE: begin
							if (!cur_valid_q) begin
								status_d = STAT_NORUN;
							end else begin
								cell_op     = OP_TERMINATE;
								cell_idx    = cur_slot_q;
								cur_valid_d = 1'b0;
								cur_slot_d  = '0;
							end
						end
						CMD_DISPATCH: begin
							if (!cur_valid_q) begin
								dispatch_d = 1'b1;
								state_d    = ST_LAUNCH;
							end
						end
						CMD_RESCHED: begin
							if (cur_valid_q) begin
								dispatch_d = 1'b0;
								state_d    = ST_LAUNCH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LAUNCH: begin
				launch  = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (chain_flags[TASK_SLOTS].valid) begin
					state_d = ST_RESULT;
					if (dispatch_q) begin
						if (chain_flags[TASK_SLOTS].found) begin
							cell_op     = OP_CLR_READY;
							cell_idx    = chain_idx[TASK_SLOTS];
							cur_valid_d = 1'b1;
							cur_slot_d  = chain_idx[TASK_SLOTS];
							cur_dl_d    = chain_dl[TASK_SLOTS];
						end else begin
							status_d = STAT_NOREADY;
						end
					end else if (chain_flags[TASK_SLOTS].hit) begin
						// running task goes back to ready
						cell_op     = OP_SET_READY;
						cell_idx    = cur_slot_q;
						cur_valid_d = 1'b0;
						cur_slot_d  = '0;
						pre_d       = 1'b1;
					end
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dispatch_q  <= 1'b0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			status_q    <= STAT_OK;
			pre_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			dispatch_q  <= dispatch_d;
			cur_valid_q <= cur_valid_d;
			cur_slot_q  <= cur_slot_d;
			status_q    <= status_d;
			pre_q       <= pre_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_dl_q <= cur_dl_d;
		if (out_load) begin
			out_status_q    <= status_q;
			out_run_valid_q <= cur_valid_q;
			out_run_slot_q  <= cur_wide[SLOT_PORT_W-1:0];
			out_pre_q       <= pre_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign running_valid = out_run_valid_q;
	assign running_slot  = out_run_slot_q;
	assign preempted     = out_pre_q;

	// scan token only comes out of the chain while the controller waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		chain_flags[TASK_SLOTS].valid |-> state_q == ST_WAIT)
		else $error("scan result outside of wait state");

	// the running slot is always an active slot
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> active_vec[cur_slot_q])
		else $error("running slot is not active");

	// an accepted command is executed in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_EXEC)
		else $error("accepted command not executed");

	// a finished result reaches the output register when it has room
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && !(out_valid_q && out_stall) |=>
			out_valid_q && state_q == ST_IDLE)
		else $error("result not delivered");

	// a preemption always leaves nothing running
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_pre_q |-> !out_run_valid_q)
		else $error("preempted result shows a running task");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the EDF task scheduler. A short table of directed
// commands walks the error codes, ties and preemption paths, then weighted
// random commands run through several enable settings. Every result is
// compared field by field with an in-bench scheduler model; both channels
// get random stall/idle bursts, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import edf_pkg::*;

	localparam int TASK_SLOTS = DEF_TASK_SLOTS;
	localparam int DL_BITS    = DEF_DEADLINE_BITS;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam int NUM_PHASES  = 5;

	// command codes that the block has no name for
	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

	typedef struct packed {
		status_t                 status;
		logic                    run_valid;
		logic [SLOT_PORT_W-1:0]  run_slot;
		logic                    pre;
	} sched_result_t;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic                    cfg_val;
		logic [CMD_W-1:0]        cmd;
		logic [SLOT_PORT_W-1:0]  slot;
		logic [DL_PORT_W-1:0]    dl;
		logic                    typed;
		sched_result_t           res;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        cmd = '0;
	logic [SLOT_PORT_W-1:0]  task_slot = '0;
	logic [DL_PORT_W-1:0]    task_deadline = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic                    running_valid;
	logic [SLOT_PORT_W-1:0]  running_slot;
	logic                    preempted;

	edf_task_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.task_slot     (task_slot),
		.task_deadline (task_deadline),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.running_valid (running_valid),
		.running_slot  (running_slot),
		.preempted     (preempted)
	);

	always #1 clk = ~clk;

	// scheduler model state
	logic                    mdl_enable = 1'b0;
	logic                    mdl_active [TASK_SLOTS];
	logic                    mdl_ready  [TASK_SLOTS];
	logic [DL_BITS-1:0]      mdl_dl     [TASK_SLOTS];
	logic [SLOT_PORT_W-1:0]  mdl_cur = '0;
	logic                    mdl_cur_valid = 1'b0;

	sched_result_t           sched_exp_q [$];
	stim_row_t               dir_tab [$];

	int n_err = 0;
	int n_items = 0;
	int n_results = 0;
	int n_preempts = 0;
	int n_started = 0;
	int n_cfg = 0;
	int quiet_cycles = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_req = 1'b0;

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			mdl_active[i] = 1'b0;
			mdl_ready[i]  = 1'b0;
			mdl_dl[i]     = '0;
		end
	end

	// running task goes back to ready when a ready slot is strictly more urgent
	function automatic logic edf_preempt();
		if (!mdl_cur_valid)
			return 1'b0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (mdl_active[i] && mdl_ready[i] && mdl_dl[i] < mdl_dl[mdl_cur]) begin
				mdl_ready[mdl_cur] = 1'b1;
				mdl_cur_valid = 1'b0;
				mdl_cur = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic sched_result_t edf_schedule(logic [CMD_W-1:0] c,
			logic [SLOT_PORT_W-1:0] s, logic [DL_PORT_W-1:0] d);
		sched_result_t r;
		int best;
		logic found;
		r.status = STAT_OK;
		r.pre = 1'b0;
		best = 0;
		found = 1'b0;
		if (!mdl_enable) begin
			r.status = STAT_DISABLED;
		end else if (c == CMD_ACT_TASK || c == CMD_ACT_IRQ) begin
			if (mdl_active[s]) begin
				r.status = STAT_DUP;
			end else begin
				mdl_active[s] = 1'b1;
				mdl_ready[s]  = 1'b1;
				mdl_dl[s]     = d[DL_BITS-1:0];
				if (c == CMD_ACT_TASK)
					r.pre = edf_preempt();
			end
		end else if (c == CMD_TERMINATE) begin
			if (!mdl_cur_valid) begin
				r.status = STAT_NORUN;
			end else begin
				mdl_active[mdl_cur] = 1'b0;
				mdl_ready[mdl_cur]  = 1'b0;
				mdl_cur_valid = 1'b0;
				mdl_cur = '0;
			end
		end else if (c == CMD_DISPATCH) begin
			if (!mdl_cur_valid) begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (mdl_active[i] && mdl_ready[i] && (!found || mdl_dl[i] < mdl_dl[best])) begin
						best = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = STAT_NOREADY;
				end else begin
					mdl_ready[best] = 1'b0;
					mdl_cur = best[SLOT_PORT_W-1:0];
					mdl_cur_valid = 1'b1;
				end
			end
		end else if (c == CMD_RESCHED) begin
			r.pre = edf_preempt();
		end
		r.run_valid = mdl_cur_valid;
		r.run_slot  = mdl_cur_valid ? mdl_cur : '0;
		return r;
	endfunction

	// only called with the input side idle and nothing outstanding
	task automatic set_enable(input logic v);
		in_valid <= 1'b0;
		while (sched_exp_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		mdl_enable = v;
		n_cfg++;
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [SLOT_PORT_W-1:0] s,
			input logic [DL_PORT_W-1:0] d, input logic typed, input sched_result_t typed_res);
		sched_result_t r;
		if (tx_idle_en && (n_items % 100) < 70 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		task_slot     <= s;
		task_deadline <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = edf_schedule(c, s, d);
		sched_exp_q.push_back(typed ? typed_res : r);
		n_items++;
	endtask

	function automatic logic [DL_PORT_W-1:0] rand_deadline();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		if (k < 6)
			return DL_PORT_W'($urandom_range(0, 15));  // narrow range forces ties
		return DL_PORT_W'($urandom);
	endfunction

	function automatic logic [CMD_W-1:0] rand_cmd();
		int w;
		w = $urandom_range(0, 99);
		if (w < 22) return CMD_ACT_TASK;
		if (w < 35) return CMD_ACT_IRQ;
		if (w < 55) return CMD_TERMINATE;
		if (w < 80) return CMD_DISPATCH;
		if (w < 95) return CMD_RESCHED;
		return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
	endfunction

	// output side: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (preempted === 1'b1)
				n_preempts++;
			if (sched_exp_q.size() == 0) begin
				$display("%0t: result with no transaction pending: status=%0d run=%b/%0d pre=%b",
					$time, status, running_valid, running_slot, preempted);
				n_err++;
			end else begin
				e = sched_exp_q.pop_front();
				if (e.run_valid && e.status == STAT_OK)
					n_started++;
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					n_err++;
				end
				if (running_valid !== e.run_valid) begin
					$display("%0t: running_valid expected %b actual %b",
						$time, e.run_valid, running_valid);
					n_err++;
				end
				if (running_slot !== e.run_slot) begin
					$display("%0t: running_slot expected %0d actual %0d",
						$time, e.run_slot, running_slot);
					n_err++;
				end
				if (preempted !== e.pre) begin
					$display("%0t: preempted expected %b actual %b", $time, e.pre, preempted);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int phase_len [NUM_PHASES];
		logic phase_en [NUM_PHASES];
		stim_row_t row;
		phase_len = '{420, 40, 300, 280, 60};
		phase_en  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

		// disabled after reset
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_TASK, 3'd0, 16'h0000, 1'b1,
			'{STAT_DISABLED, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_SPARE_HI, 3'd7, 16'hFFFF, 1'b1,
			'{STAT_DISABLED, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CFG, 1'b1, '0, '0, '0, 1'b0, '0});
		// empty table: error codes, harmless no-ops and the first activations
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_TERMINATE, 3'd0, 16'h0000, 1'b1,
			'{STAT_NORUN, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b1,
			'{STAT_NOREADY, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_RESCHED, 3'd0, 16'h0000, 1'b1,
			'{STAT_OK, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_SPARE_LO, 3'd5, 16'h5555, 1'b1,
			'{STAT_OK, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_IRQ, 3'd7, 16'hFFFF, 1'b1,
			'{STAT_OK, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_TASK, 3'd7, 16'h0005, 1'b1,
			'{STAT_DUP, 1'b0, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_TASK, 3'd0, 16'hFFFF, 1'b1,
			'{STAT_OK, 1'b0, 3'd0, 1'b0}});
		// tie on max deadline goes to the lowest slot
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b1,
			'{STAT_OK, 1'b1, 3'd0, 1'b0}});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_IRQ, 3'd3, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_RESCHED, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b0, '0});
		// equal deadline must not preempt
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_TASK, 3'd4, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_RESCHED, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_TERMINATE, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_TERMINATE, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_TERMINATE, 3'd0, 16'h0000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd0, 16'h0000, 1'b0, '0});
		// activation from a task preempts on its own
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_ACT_TASK, 3'd2, 16'h8000, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_SPARE_MID, 3'd6, 16'hAAAA, 1'b0, '0});
		dir_tab.push_back('{ROW_CFG, 1'b0, '0, '0, '0, 1'b0, '0});
		dir_tab.push_back('{ROW_CMD, 1'b0, CMD_DISPATCH, 3'd1, 16'h1234, 1'b1,
			'{STAT_DISABLED, 1'b0, 3'd0, 1'b0}});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.kind == ROW_CFG)
				set_enable(row.cfg_val);
			else
				send_cmd(row.cmd, row.slot, row.dl, row.typed, row.res);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			set_enable(phase_en[p]);
			for (int k = 0; k < phase_len[p]; k++) begin
				if (p == 0 && k == 120)
					hold_req = 1'b1;  // output held off while commands keep coming
				send_cmd(rand_cmd(), SLOT_PORT_W'($urandom_range(0, TASK_SLOTS - 1)),
					rand_deadline(), 1'b0, '0);
				if (p == 0 && k == 300) begin
					in_valid <= 1'b0;
					while (sched_exp_q.size() != 0)
						@(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		while (sched_exp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d commands, %0d results checked, %0d enable writes.",
			n_items, n_results, n_cfg);
		$display("Saw %0d preemptions and %0d results with a task running; %0d mismatches.",
			n_preempts, n_started, n_err);
		if (n_err == 0 && sched_exp_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
design/edf_pkg.sv
design/edf_cell.sv
design/edf_task_scheduler.sv
tb/sv/tb.sv
